### sv/mwf_pkg.sv
// Shared types, codes and default sizes for the mutex with waiter FIFO.
`default_nettype none

package mwf_pkg;

    localparam int WAIT_DEPTH_DEF = 16;
    localparam int PID_BITS_DEF   = 8;

    localparam int FUNC_W   = 2;
    localparam int PID_W    = 8;
    localparam int STATUS_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_LOCK   = 2'd0,
        FN_TRY    = 2'd1,
        FN_UNLOCK = 2'd2,
        FN_UNUSED = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_ALREADY    = 3'd1,
        ST_QUEUED     = 3'd2,
        ST_BUSY       = 3'd3,
        ST_NOT_HOLDER = 3'd4,
        ST_FULL       = 3'd5,
        ST_BAD_PID    = 3'd6
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_WAKE = 1'b1
    } t_state;

endpackage

`default_nettype wire

### sv/mwf_wait_ram.sv
// Waiter id store: one write port and one registered read port.
`default_nettype none

module mwf_wait_ram #(
    parameter int DEPTH     = mwf_pkg::WAIT_DEPTH_DEF,
    parameter int DATA_BITS = mwf_pkg::PID_BITS_DEF,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_wr_en,
    input  wire logic [ADDR_BITS-1:0] i_wr_addr,
    input  wire logic [DATA_BITS-1:0] i_wr_data,
    input  wire logic                 i_rd_en,
    input  wire logic [ADDR_BITS-1:0] i_rd_addr,
    output logic      [DATA_BITS-1:0] o_rd_data
);

    logic [DATA_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### sv/mutex_with_waiter_fifo.sv
// Mutex with a bounded FIFO of waiting process ids.
//
// Input channel: i_valid, i_func, i_pid; the block holds it off with o_stall.
// A request is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid, o_status, o_wake_valid, o_wake_pid; the receiver
// holds it off with i_stall, and a held result stays unchanged.
// Every request yields exactly one result. Lock requests, whether they may
// queue or not, rejected requests and an unlock with no waiter present their
// result in the cycle after accept.
// An unlock that wakes a waiter reads the head entry of the waiter memory
// through its registered read port; the entry arrives in the S_WAKE state and
// then goes to the output register; the block takes no request in between.
// Throughput is one request per cycle but for stalls and unlocks that wake.
// A new request is taken while a result is being taken in the same cycle.
// While the receiver stalls, the result waits in the output register and
// new requests are held off.
// Reset frees the mutex and empties the queue; the waiter memory is not
// cleared, since only written entries are ever read.
`default_nettype none

module mutex_with_waiter_fifo #(
    parameter int WAIT_DEPTH = mwf_pkg::WAIT_DEPTH_DEF,
    parameter int PID_BITS   = mwf_pkg::PID_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [mwf_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [mwf_pkg::PID_W-1:0]     i_pid,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [mwf_pkg::STATUS_W-1:0]  o_status,
    output logic                               o_wake_valid,
    output logic      [mwf_pkg::PID_W-1:0]     o_wake_pid
);

    import mwf_pkg::*;

    localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam int PW = (PID_BITS < PID_W) ? PID_BITS : PID_W;
    localparam logic [AW-1:0] LAST_SLOT = AW'(WAIT_DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(WAIT_DEPTH);

    t_state          r_state, n_state;
    logic            r_locked, n_locked;
    logic [PW-1:0]   r_holder, n_holder;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    logic            r_out_valid, n_out_valid;
    t_status         r_out_status, n_out_status;
    logic            r_out_wake, n_out_wake;
    logic [PW-1:0]   r_out_pid, n_out_pid;

    logic            accept;
    logic            out_free;
    logic [PW-1:0]   pid;
    logic            wr_en;
    logic            rd_en;
    logic [PW-1:0]   rd_data;

    assign pid      = i_pid[PW-1:0];
    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = (r_state != S_IDLE) || !out_free;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        n_state      = r_state;
        n_locked     = r_locked;
        n_holder     = r_holder;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_out_valid  = r_out_valid && i_stall;
        n_out_status = r_out_status;
        n_out_wake   = r_out_wake;
        n_out_pid    = r_out_pid;
        wr_en        = 1'b0;
        rd_en        = 1'b0;

        unique case (r_state)
            S_WAKE: begin
                // Head entry arrives from the memory now.
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_wake   = 1'b1;
                n_out_pid    = rd_data;
                n_state      = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    n_out_valid  = 1'b1;
                    n_out_wake   = 1'b0;
                    n_out_pid    = '0;
                    priority if (pid == '0 || i_func == FN_UNUSED) begin
                        n_out_status = ST_BAD_PID;
                    end else if (i_func == FN_UNLOCK) begin
                        if (!r_locked || r_holder != pid) begin
                            n_out_status = ST_NOT_HOLDER;
                        end else begin
                            n_locked     = 1'b0;
                            n_holder     = '0;
                            n_out_status = ST_OK;
                            if (r_count != '0) begin
                                rd_en       = 1'b1;
                                n_out_valid = 1'b0;
                                n_state     = S_WAKE;
                                n_head      = (r_head == LAST_SLOT) ? '0 : r_head + 1'b1;
                                n_count     = r_count - 1'b1;
                            end
                        end
                    end else if (r_locked && r_holder == pid) begin
                        n_out_status = ST_ALREADY;
                    end else if (!r_locked) begin
                        n_locked     = 1'b1;
                        n_holder     = pid;
                        n_out_status = ST_OK;
                    end else if (i_func == FN_TRY) begin
                        n_out_status = ST_BUSY;
                    end else if (r_count >= FULL_COUNT) begin
                        n_out_status = ST_FULL;
                    end else begin
                        wr_en        = 1'b1;
                        n_tail       = (r_tail == LAST_SLOT) ? '0 : r_tail + 1'b1;
                        n_count      = r_count + 1'b1;
                        n_out_status = ST_QUEUED;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_locked    <= 1'b0;
            r_holder    <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_locked    <= n_locked;
            r_holder    <= n_holder;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_wake   <= n_out_wake;
        r_out_pid    <= n_out_pid;
    end

    mwf_wait_ram #(
        .DEPTH     (WAIT_DEPTH),
        .DATA_BITS (PW),
        .ADDR_BITS (AW)
    ) u_wait_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (pid),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (rd_data)
    );

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_wake_valid = r_out_wake;
    assign o_wake_pid   = PID_W'(r_out_pid);

endmodule

`default_nettype wire

### test/tb_mutex_with_waiter_fifo.sv
// Self-checking testbench for the mutex with waiter FIFO: directed and random requests.
`timescale 1ns / 100ps

module tb_mutex_with_waiter_fifo;

    import mwf_pkg::*;

    localparam int WAIT_SLOTS      = WAIT_DEPTH_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int MAX_PRINTED     = 100;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_REQUESTS  = 100;

    typedef struct packed {
        t_status          status;
        logic             wake;
        logic [PID_W-1:0] wake_pid;
    } t_mutex_reply;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic [FUNC_W-1:0]   i_func = FN_LOCK;
    logic [PID_W-1:0]    i_pid = '0;
    logic                i_stall = 1'b0;
    logic                o_stall;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic                o_wake_valid;
    logic [PID_W-1:0]    o_wake_pid;

    // Shadow of the mutex as the block should hold it.
    logic               mutex_locked = 1'b0;
    logic [PID_W-1:0]   mutex_owner = '0;
    logic [PID_W-1:0]   waiters[$];

    t_mutex_reply       pending_replies[$];
    logic [PID_W-1:0]   woken_pid = '0;
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;
    int                 stall_left = 0;
    bit                 no_idle = 1'b0;
    bit                 hold_off_toggle = 1'b0;
    bit                 hold_off_seen = 1'b0;

    mutex_with_waiter_fifo u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_func       (i_func),
        .i_pid        (i_pid),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_wake_valid (o_wake_valid),
        .o_wake_pid   (o_wake_pid)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_idle_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    // Half the pids come from a tiny pool so that holders and waiters collide.
    function automatic logic [PID_W-1:0] pick_pid();
        if ($urandom_range(0, 1) == 0) return PID_W'($urandom_range(1, 4));
        return PID_W'($urandom_range(1, 255));
    endfunction

    function automatic logic [PID_W-1:0] pick_other_pid();
        logic [PID_W-1:0] p;
        do p = pick_pid(); while (p == mutex_owner);
        return p;
    endfunction

    function automatic t_mutex_reply predict_reply(logic [FUNC_W-1:0] f, logic [PID_W-1:0] pid);
        t_mutex_reply r;
        r.status   = ST_OK;
        r.wake     = 1'b0;
        r.wake_pid = '0;
        if (pid == '0 || f > FN_UNLOCK) begin
            r.status = ST_BAD_PID;
        end else if (f == FN_UNLOCK) begin
            if (!mutex_locked || mutex_owner != pid) begin
                r.status = ST_NOT_HOLDER;
            end else begin
                mutex_locked = 1'b0;
                mutex_owner  = '0;
                if (waiters.size() > 0) begin
                    r.wake     = 1'b1;
                    r.wake_pid = waiters.pop_front();
                end
            end
        end else if (mutex_locked && mutex_owner == pid) begin
            r.status = ST_ALREADY;
        end else if (!mutex_locked) begin
            mutex_locked = 1'b1;
            mutex_owner  = pid;
        end else if (f == FN_TRY) begin
            r.status = ST_BUSY;
        end else if (waiters.size() >= WAIT_SLOTS) begin
            r.status = ST_FULL;
        end else begin
            waiters.push_back(pid);
            r.status = ST_QUEUED;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (mismatch_count < MAX_PRINTED)
            $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Valid stays high after an accept; the next call either keeps it high or drops it for a gap.
    task automatic send_request(logic [FUNC_W-1:0] f, logic [PID_W-1:0] pid,
                                output t_mutex_reply pred);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 99) < 30) gap = pick_idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_func  <= f;
        i_pid   <= pid;
        do @(posedge i_clk); while (o_stall);
        pred = predict_reply(f, pid);
        pending_replies.push_back(pred);
        if (pred.wake) woken_pid = pred.wake_pid;
    endtask

    // Mostly well-formed traffic: a woken process retries, the holder unlocks, others queue.
    task automatic send_random_request(int crowd_pct);
        logic [FUNC_W-1:0] f;
        logic [PID_W-1:0]  pid;
        t_mutex_reply      pred;
        if ($urandom_range(0, 99) < 15) begin
            f   = FUNC_W'($urandom_range(0, 3));
            pid = PID_W'($urandom_range(0, 255));
        end else if (!mutex_locked) begin
            f = ($urandom_range(0, 3) == 0) ? FN_TRY : FN_LOCK;
            if (woken_pid != '0) begin
                pid       = woken_pid;
                woken_pid = '0;
            end else begin
                pid = pick_pid();
            end
        end else if ($urandom_range(0, 99) < crowd_pct) begin
            f   = ($urandom_range(0, 9) == 0) ? FN_TRY : FN_LOCK;
            pid = ($urandom_range(0, 19) == 0) ? mutex_owner : pick_other_pid();
        end else begin
            f   = FN_UNLOCK;
            pid = ($urandom_range(0, 9) == 0) ? pick_other_pid() : mutex_owner;
        end
        send_request(f, pid, pred);
    endtask

    task automatic test_rejected_requests();
        t_mutex_reply pred;
        send_request(FN_LOCK, 8'h00, pred);
        send_request(FN_TRY, 8'h00, pred);
        send_request(FN_UNLOCK, 8'h00, pred);
        send_request(FN_UNUSED, 8'hA5, pred);
        send_request(FN_UNUSED, 8'h00, pred);
    endtask

    task automatic test_lock_and_unlock();
        t_mutex_reply pred;
        send_request(FN_UNLOCK, 8'h01, pred);
        send_request(FN_TRY, 8'hFF, pred);
        send_request(FN_LOCK, 8'hFF, pred);
        send_request(FN_TRY, 8'hFF, pred);
        send_request(FN_TRY, 8'h01, pred);
        send_request(FN_UNLOCK, 8'h01, pred);
        send_request(FN_UNLOCK, 8'hFF, pred);
    endtask

    // The same pid queued twice is woken twice, in arrival order.
    task automatic test_waiter_wakeup();
        t_mutex_reply pred;
        send_request(FN_LOCK, 8'h80, pred);
        send_request(FN_LOCK, 8'h01, pred);
        send_request(FN_LOCK, 8'h01, pred);
        send_request(FN_LOCK, 8'h7F, pred);
        send_request(FN_UNLOCK, 8'h80, pred);
        send_request(FN_LOCK, 8'h01, pred);
        send_request(FN_UNLOCK, 8'h01, pred);
        send_request(FN_LOCK, 8'h01, pred);
        send_request(FN_UNLOCK, 8'h01, pred);
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_off_toggle <= ~hold_off_toggle;
        repeat (30) send_random_request(50);
        no_idle = 1'b0;
    endtask

    task automatic test_full_queue();
        t_mutex_reply pred;
        if (!mutex_locked) send_request(FN_LOCK, pick_pid(), pred);
        while (waiters.size() < WAIT_SLOTS) send_request(FN_LOCK, pick_other_pid(), pred);
        send_request(FN_LOCK, pick_other_pid(), pred);
        send_request(FN_TRY, pick_other_pid(), pred);
        while (waiters.size() > 0) begin
            send_request(FN_UNLOCK, mutex_owner, pred);
            send_request(FN_LOCK, pred.wake_pid, pred);
        end
        woken_pid = '0;
    endtask

    task automatic test_random_traffic();
        int crowd_pct;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 2))
                0: crowd_pct = 20;
                1: crowd_pct = 50;
                default: crowd_pct = 85;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (PHASE_REQUESTS) send_random_request(crowd_pct);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (hold_off_toggle != hold_off_seen) begin
                hold_off_seen = hold_off_toggle;
                stall_left    = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!no_idle && $urandom_range(0, 99) < 20) begin
                stall_left = pick_idle_len() - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_replies
        t_mutex_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("result with no request pending", o_status, -1);
            end else begin
                want = pending_replies.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_wake_valid !== want.wake)
                    report_mismatch("wake_valid", o_wake_valid, want.wake);
                if (o_wake_pid !== want.wake_pid)
                    report_mismatch("wake_pid", o_wake_pid, want.wake_pid);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_rejected_requests();
        test_lock_and_unlock();
        test_waiter_wakeup();
        test_backpressure();
        test_full_queue();
        test_random_traffic();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
